>>> src/colormap_lookup_interpolate_macros.svh
// Assertion macros used by the colormap lookup top level.
`ifndef COLORMAP_LOOKUP_INTERPOLATE_MACROS_SVH
`define COLORMAP_LOOKUP_INTERPOLATE_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define CLUT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define CLUT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `CLUT_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define CLUT_ASSERT(lbl, prop, msg)
`define CLUT_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

>>> src/clut_pkg.sv
// Types, constants and register codes for the colormap lookup block.
package clut_pkg;

  localparam int TABLE_DEPTH_DEF          = 1024;
  localparam int SAMPLE_FRACTION_BITS_DEF = 16;

  localparam int ENTRY_INDEX_W = 10;
  localparam int ENTRIES_W     = 11;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 2;

  localparam logic signed [31:0]    RANGE_MIN_RST      = 32'sd0;
  localparam logic signed [31:0]    INVERSE_SPAN_RST   = 32'sd65536;
  localparam logic [ENTRIES_W-1:0]  ENTRIES_IN_USE_RST = 11'd1024;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_MAP   = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RANGE_MIN      = 2'd0,
    CFG_INVERSE_SPAN   = 2'd1,
    CFG_ENTRIES_IN_USE = 2'd2
  } cfg_reg_e;

  // Where a normalized sample falls relative to the table span.
  typedef enum logic [1:0] {
    POS_LOW  = 2'd0,
    POS_MID  = 2'd1,
    POS_HIGH = 2'd2
  } pos_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic                     mode;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [7:0]               entry_red;
    logic [7:0]               entry_green;
    logic [7:0]               entry_blue;
    logic signed [31:0]       sample_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

endpackage

>>> src/clut_ram.sv
// Generic RAM with one write port and two registered read ports.
module clut_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/clut_front.sv
// Front pipeline: sample offset, normalization multiply, range check and scaling.
module clut_front import clut_pkg::*; #(
  parameter int TABLE_DEPTH          = TABLE_DEPTH_DEF,
  parameter int SAMPLE_FRACTION_BITS = SAMPLE_FRACTION_BITS_DEF,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int NB = 2 * SAMPLE_FRACTION_BITS,
  localparam int PW = NB + AW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_item_i,
  input  logic signed [31:0]       range_min_i,
  input  logic signed [31:0]       inverse_span_i,
  input  logic [AW-1:0]            n_m1_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     out_mode_o,
  output logic [ENTRY_INDEX_W-1:0] out_index_o,
  output color_t                   out_color_o,
  output pos_e                     out_pos_o,
  output logic [PW-1:0]            out_prod_o
);

  localparam logic signed [63:0] ONE = 64'sd1 <<< NB;

  // Stage 1: registered input item.
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // Stage 2: sample minus range start.
  logic                     s2_valid_q;
  logic                     s2_mode_q;
  logic [ENTRY_INDEX_W-1:0] s2_index_q;
  color_t                   s2_color_q;
  logic signed [32:0]       s2_diff_q;
  logic signed [32:0]       s2_diff_d;

  // Stage 3: normalized position with NB fraction bits.
  logic                     s3_valid_q;
  logic                     s3_mode_q;
  logic [ENTRY_INDEX_W-1:0] s3_index_q;
  color_t                   s3_color_q;
  logic signed [63:0]       s3_x_q;
  logic signed [63:0]       s3_x_d;

  // Stage 4: position class and position scaled to the table span.
  logic                     s4_valid_q;
  logic                     s4_mode_q;
  logic [ENTRY_INDEX_W-1:0] s4_index_q;
  color_t                   s4_color_q;
  pos_e                     s4_pos_q;
  pos_e                     s4_pos_d;
  logic [PW-1:0]            s4_prod_q;
  logic [PW-1:0]            s4_prod_d;

  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign s2_diff_d = {s1_item_q.sample_value[31], s1_item_q.sample_value}
                   - {range_min_i[31], range_min_i};

  assign s3_x_d = s2_diff_q * inverse_span_i;

  always_comb begin
    if (s3_x_q <= 64'sd0) begin
      s4_pos_d = POS_LOW;
    end else if (s3_x_q >= ONE) begin
      s4_pos_d = POS_HIGH;
    end else begin
      s4_pos_d = POS_MID;
    end
    s4_prod_d = PW'(s3_x_q[NB-1:0]) * PW'(n_m1_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_item_q <= in_item_i;
    end
    if (s2_ready) begin
      s2_mode_q  <= s1_item_q.mode;
      s2_index_q <= s1_item_q.entry_index;
      s2_color_q <= '{red:   s1_item_q.entry_red,
                      green: s1_item_q.entry_green,
                      blue:  s1_item_q.entry_blue};
      s2_diff_q  <= s2_diff_d;
    end
    if (s3_ready) begin
      s3_mode_q  <= s2_mode_q;
      s3_index_q <= s2_index_q;
      s3_color_q <= s2_color_q;
      s3_x_q     <= s3_x_d;
    end
    if (s4_ready) begin
      s4_mode_q  <= s3_mode_q;
      s4_index_q <= s3_index_q;
      s4_color_q <= s3_color_q;
      s4_pos_q   <= s4_pos_d;
      s4_prod_q  <= s4_prod_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_mode_o  = s4_mode_q;
  assign out_index_o = s4_index_q;
  assign out_color_o = s4_color_q;
  assign out_pos_o   = s4_pos_q;
  assign out_prod_o  = s4_prod_q;

endmodule

>>> src/clut_blend.sv
// Back pipeline: weights the two neighboring entries and rounds each channel.
module clut_blend import clut_pkg::*; #(
  parameter int SAMPLE_FRACTION_BITS = SAMPLE_FRACTION_BITS_DEF,
  localparam int NB = 2 * SAMPLE_FRACTION_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [NB-1:0] frac_i,
  input  color_t        color_a_i,
  input  color_t        color_b_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_item_t     out_item_o
);

  localparam logic signed [NB+9:0] HALF = (NB+10)'(1) << (NB - 1);

  logic [2:0][7:0] chan_a;
  logic [2:0][7:0] chan_b;

  // Stage 6: a*(1-f) + b*f is formed as a*1 + (b-a)*f, one product per channel.
  logic                      s6_valid_q;
  logic [2:0][7:0]           s6_base_q;
  logic signed [NB+9:0]      s6_prod_q [3];
  logic signed [NB+9:0]      s6_prod_d [3];

  // Stage 7: rounded result held until taken.
  logic                      s7_valid_q;
  logic [2:0][7:0]           s7_chan_q;
  logic [2:0][7:0]           s7_chan_d;
  logic signed [NB+9:0]      sum [3];

  logic s6_ready, s7_ready;

  assign chan_a = color_a_i;
  assign chan_b = color_b_i;

  assign s7_ready   = !s7_valid_q || out_ready_i;
  assign s6_ready   = !s6_valid_q || s7_ready;
  assign in_ready_o = s6_ready;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s6_prod_d[c] = ($signed({1'b0, chan_b[c]}) - $signed({1'b0, chan_a[c]}))
                   * $signed({1'b0, frac_i});
      sum[c]       = $signed({2'b00, s6_base_q[c], {NB{1'b0}}}) + s6_prod_q[c] + HALF;
      s7_chan_d[c] = sum[c][NB+7:NB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
    end else begin
      if (s6_ready) s6_valid_q <= in_valid_i;
      if (s7_ready) s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s6_ready) begin
      s6_base_q <= chan_a;
      for (int c = 0; c < 3; c++) begin
        s6_prod_q[c] <= s6_prod_d[c];
      end
    end
    if (s7_ready) begin
      s7_chan_q <= s7_chan_d;
    end
  end

  assign out_valid_o = s7_valid_q;
  assign out_item_o  = '{out_red:   s7_chan_q[2],
                         out_green: s7_chan_q[1],
                         out_blue:  s7_chan_q[0]};

endmodule

>>> src/colormap_lookup_interpolate.sv
// Colormap lookup with linear interpolation: top level. Each item either writes
// one 24-bit entry of the color table (mode 0, no result) or maps a signed Q16.16
// sample to an RGB color (mode 1, one result). The sample is normalized as
// (sample - range_min) * inverse_span; at or below zero it gives entry 0, at or
// above one it gives the last entry in use, and in between the two neighboring
// entries are blended by the fractional position and rounded half up per channel.
// The block takes one item every clock cycle for as long as the output side keeps
// up. The pipeline has seven register stages: input, offset, normalize multiply,
// range check and scale, table read, blend multiply, round. Table writes land in
// the RAM in the table-read stage, in item order, so a sample that follows a write
// sees it. Table entries hold no defined value until written, and there is no
// clearing pass after reset. Configuration registers are written through a plain
// write port and must only change while no item is in flight.
`include "colormap_lookup_interpolate_macros.svh"

module colormap_lookup_interpolate import clut_pkg::*; #(
  parameter int TABLE_DEPTH          = TABLE_DEPTH_DEF,
  parameter int SAMPLE_FRACTION_BITS = SAMPLE_FRACTION_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NB = 2 * SAMPLE_FRACTION_BITS;
  localparam int PW = NB + AW;
  // Wide enough to compare the entry count register against the table depth.
  localparam int CW = ((AW > ENTRIES_W) ? AW : ENTRIES_W) + 1;

  // Configuration registers.
  logic signed [31:0]   range_min_q;
  logic signed [31:0]   inverse_span_q;
  logic [ENTRIES_W-1:0] entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q    <= RANGE_MIN_RST;
      inverse_span_q <= INVERSE_SPAN_RST;
      entries_q      <= ENTRIES_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RANGE_MIN:      range_min_q    <= $signed(cfg_data_i[31:0]);
        CFG_INVERSE_SPAN:   inverse_span_q <= $signed(cfg_data_i[31:0]);
        CFG_ENTRIES_IN_USE: entries_q      <= cfg_data_i[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // The entry count is clamped to [2, TABLE_DEPTH]; only count - 1 is needed,
  // as the index of the last entry and as the scale of the position.
  logic [CW-1:0] entries_w;
  logic [AW-1:0] n_m1;

  always_comb begin
    entries_w = CW'(entries_q);
    if (entries_w < CW'(2)) begin
      n_m1 = AW'(1);
    end else if (entries_w > CW'(TABLE_DEPTH)) begin
      n_m1 = AW'(TABLE_DEPTH - 1);
    end else begin
      n_m1 = AW'(entries_w - CW'(1));
    end
  end

  // Stages 1 to 4.
  logic                     fr_valid;
  logic                     fr_ready;
  logic                     fr_mode;
  logic [ENTRY_INDEX_W-1:0] fr_index;
  color_t                   fr_color;
  pos_e                     fr_pos;
  logic [PW-1:0]            fr_prod;

  clut_front #(
    .TABLE_DEPTH          (TABLE_DEPTH),
    .SAMPLE_FRACTION_BITS (SAMPLE_FRACTION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .range_min_i    (range_min_q),
    .inverse_span_i (inverse_span_q),
    .n_m1_i         (n_m1),
    .out_valid_o    (fr_valid),
    .out_ready_i    (fr_ready),
    .out_mode_o     (fr_mode),
    .out_index_o    (fr_index),
    .out_color_o    (fr_color),
    .out_pos_o      (fr_pos),
    .out_prod_o     (fr_prod)
  );

  // Stage 5: table access. The scaled position splits into the lower entry
  // index and the blend fraction. Clamped samples read one entry twice with a
  // zero fraction, which makes the blend return that entry unchanged. Since the
  // position stays below count - 1, the upper neighbor never passes the last
  // entry in use.
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [NB-1:0] frac_d;

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    frac_d = '0;
    case (fr_pos)
      POS_MID: begin
        addr_a = fr_prod[PW-1:NB];
        addr_b = fr_prod[PW-1:NB] + AW'(1);
        frac_d = fr_prod[NB-1:0];
      end
      POS_HIGH: begin
        addr_a = n_m1;
        addr_b = n_m1;
      end
      default: ;
    endcase
  end

  logic          s5_valid_q;
  pos_e          s5_pos_q;
  logic [NB-1:0] s5_frac_q;
  logic          s5_ready;
  logic          bl_ready;
  logic          ram_we;
  logic [23:0]   rd_a;
  logic [23:0]   rd_b;

  assign s5_ready = !s5_valid_q || bl_ready;
  assign fr_ready = s5_ready;

  // Writes past the end of the table are dropped. Write items leave the
  // pipeline here and never reach the blend stages.
  assign ram_we = fr_valid && s5_ready && (fr_mode == MODE_WRITE)
               && (32'(fr_index) < TABLE_DEPTH);

  clut_ram #(
    .WIDTH (24),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (AW'(fr_index)),
    .wdata_i   (fr_color),
    .re_i      (s5_ready),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (s5_ready) begin
      s5_valid_q <= fr_valid && (fr_mode == MODE_MAP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_ready) begin
      s5_pos_q  <= fr_pos;
      s5_frac_q <= frac_d;
    end
  end

  // Stages 6 and 7.
  clut_blend #(
    .SAMPLE_FRACTION_BITS (SAMPLE_FRACTION_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s5_valid_q),
    .in_ready_o  (bl_ready),
    .frac_i      (s5_frac_q),
    .color_a_i   (rd_a),
    .color_b_i   (rd_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // An empty output register must let the whole pipeline move.
  `CLUT_ASSERT_IMPLY(a_ready_when_out_empty, !out_valid_o, in_ready_o,
    "input stalled while the output register is empty")
  // Clamped samples must reach the blend with a zero fraction.
  `CLUT_ASSERT_IMPLY(a_clamped_zero_frac, s5_valid_q && (s5_pos_q != POS_MID),
    s5_frac_q == '0, "clamped sample carries a nonzero fraction")
  // A table write leaves a bubble in the table-read stage.
  `CLUT_ASSERT(a_write_no_result, ram_we |=> !s5_valid_q,
    "table write item produced a lookup")

endmodule
